FILE: sv/bitmap_page_allocator_assert.svh
// Assertion macros for the page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("bitmap_page_allocator: check failed");

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("bitmap_page_allocator: check failed");

`endif

FILE: sv/bpa_pkg.sv
package bpa_pkg;

  localparam int NUM_PAGES  = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 64;

  localparam int NWORDS = NUM_PAGES / WORD_BITS;
  localparam int PIDX_W = $clog2(NUM_PAGES);
  localparam int PAGE_W = PIDX_W + 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int OFF_W  = $clog2(PAGE_BYTES);

  localparam int STEP_BITS  = 8;
  localparam int STEP_LOG   = 3;
  localparam int NSTEPS     = WORD_BITS / STEP_BITS;
  localparam int STEP_IDX_W = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;

  localparam int ADDR_W = 64;
  localparam int CNT_W  = 17;
  localparam int FREE_W = 32;
  localparam int HI_W   = ADDR_W - OFF_W;
  localparam int UADD_W = ((PAGE_W > CNT_W) ? PAGE_W : CNT_W) + 1;

  localparam logic [CNT_W-1:0] USED_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] ACT_REGION = 2'd0;
  localparam logic [1:0] ACT_ALLOC  = 2'd1;
  localparam logic [1:0] ACT_FREE   = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
    logic              region_usable;
    logic [CNT_W-1:0]  page_count;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              found;
    logic [CNT_W-1:0]  used_count;
    logic [FREE_W-1:0] free_count;
    logic [ADDR_W-1:0] total_bytes;
  } out_item_t;

endpackage

FILE: sv/bpa_bitmap_ram.sv
module bpa_bitmap_ram import bpa_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [WIDX_W-1:0] waddr,
  input  word_t             wdata,
  input  logic [WIDX_W-1:0] raddr,
  output word_t             rdata
);

  word_t mem [NWORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bpa_run_step.sv
module bpa_run_step import bpa_pkg::*; (
  input  logic [STEP_BITS-1:0] seg,
  input  logic [PAGE_W-1:0]    run_in,
  input  logic [PAGE_W-1:0]    cnt,
  output logic [PAGE_W-1:0]    run_out,
  output logic                 hit,
  output logic [STEP_LOG-1:0]  pos
);

  logic [PAGE_W-1:0] r;

  // free-run tracking over one byte of the bitmap, lowest page first
  always_comb begin
    r   = run_in;
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      if (seg[i]) begin
        r = '0;
      end else begin
        r = r + 1'b1;
      end
      if (!hit && r == cnt) begin
        hit = 1'b1;
        pos = STEP_LOG'(i);
      end
    end
    run_out = r;
  end

endmodule

FILE: sv/bpa_mask_gen.sv
module bpa_mask_gen import bpa_pkg::*; (
  input  logic [WIDX_W-1:0] widx,
  input  logic [PIDX_W-1:0] lo,
  input  logic [PIDX_W-1:0] hi,
  output word_t             mask
);

  logic [BIT_W-1:0] lo_b;
  logic [BIT_W-1:0] hi_b;

  always_comb begin
    lo_b = (widx == WIDX_W'(lo >> BIT_W)) ? lo[BIT_W-1:0] : '0;
    hi_b = (widx == WIDX_W'(hi >> BIT_W)) ? hi[BIT_W-1:0] : '1;
    mask = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (~hi_b));
  end

endmodule

FILE: sv/bitmap_page_allocator.sv
// First-fit page allocator over a used-bit bitmap held in a 1024 x 64 RAM with one
// read and one write port. After reset the block runs a clearing pass that marks
// every page used; busy is high meanwhile. An item is taken when start is high and
// busy is low, and its result appears on result with done high for exactly one
// cycle; the receiver cannot stall it, so it must take every done. Add region goes
// straight to the report when not usable, else sums, clamps and counts the pages,
// then, if any whole page lies in it, read-modify-writes each bitmap word it touches;
// free subtracts the offset, checks the page bit and clears it if set; an unknown
// action reports at once. Allocate: a zero or oversized count reports at once; else
// the search reads one word per cycle while words are all free or all used, and a
// mixed word holds it for a word look plus one byte a cycle in the run-scan step; a
// hit then marks each word and forms the address, a miss reports. The user must write
// virt_offset through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_item_t          cmd,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output logic              done,
  output out_item_t         result
);

  typedef enum logic [12:0] {
    S_INIT     = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_RG_SUM   = 13'b0000000000100,
    S_RG_CLAMP = 13'b0000000001000,
    S_RG_CNT   = 13'b0000000010000,
    S_SCAN     = 13'b0000000100000,
    S_BYTE     = 13'b0000001000000,
    S_AL_MARK  = 13'b0000010000000,
    S_RMW      = 13'b0000100000000,
    S_AL_ADDR  = 13'b0001000000000,
    S_FR_SUB   = 13'b0010000000000,
    S_FR_CHK   = 13'b0100000000000,
    S_REPORT   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  logic [WIDX_W-1:0]     widx, widx_next;
  logic [STEP_IDX_W-1:0] bidx, bidx_next;
  logic [PAGE_W-1:0]     run, run_next;

  logic [ADDR_W-1:0] virt_offset;
  logic [CNT_W-1:0]  pages_held;
  logic [FREE_W-1:0] usable_pages;
  logic [ADDR_W-1:0] memory_bytes;

  in_item_t          cmd_q;
  word_t             word_q;
  logic [ADDR_W:0]   sum_q;
  logic [HI_W:0]     first_q;
  logic [PAGE_W-1:0] fc, lc;
  logic [PIDX_W-1:0] lo, hi, start_q;
  logic              op_set;
  logic              fr_ok;
  logic [BIT_W-1:0]  fbit;
  logic [ADDR_W-1:0] addr_q;
  logic              found_q;

  word_t rdata;
  word_t mask;
  logic  mem_we;
  word_t mem_wdata;

  logic                 accept;
  logic [PAGE_W-1:0]    cnt;
  logic                 word_all_used, word_all_free;
  logic [PAGE_W:0]      run_wide;
  logic                 zw_hit;
  logic [PIDX_W-1:0]    zw_start;
  logic [STEP_BITS-1:0] seg;
  logic [PAGE_W-1:0]    st_run;
  logic                 st_hit;
  logic [STEP_LOG-1:0]  st_pos;
  logic [PIDX_W-1:0]    byte_page;
  logic [PAGE_W-1:0]    by_start_w;
  logic                 rmw_last, scan_last, byte_last;
  logic [PAGE_W-1:0]    first_c, last_c;
  logic [ADDR_W-1:0]    fr_diff;
  logic                 free_hit;
  logic                 alloc_ok;
  logic [FREE_W:0]      usable_sum;
  logic [UADD_W-1:0]    used_sum;
  logic [FREE_W-1:0]    free_cnt;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign cnt           = PAGE_W'(cmd_q.page_count);
  assign word_all_used = &rdata;
  assign word_all_free = ~|rdata;
  assign run_wide      = {1'b0, run} + (PAGE_W + 1)'(WORD_BITS);
  assign zw_hit        = run_wide >= {1'b0, cnt};
  assign zw_start      = (PIDX_W'(widx) << BIT_W) - PIDX_W'(run);
  assign seg           = word_q[bidx * STEP_BITS +: STEP_BITS];
  assign byte_page     = (PIDX_W'(widx) << BIT_W) | (PIDX_W'(bidx) << STEP_LOG)
                         | PIDX_W'(st_pos);
  assign by_start_w    = {1'b0, byte_page} + PAGE_W'(1) - cnt;
  assign rmw_last      = (widx == WIDX_W'(hi >> BIT_W));
  assign scan_last     = (widx == WIDX_W'(NWORDS - 1));
  assign byte_last     = (bidx == STEP_IDX_W'(NSTEPS - 1));

  assign first_c = (first_q > (HI_W + 1)'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES)
                                                      : PAGE_W'(first_q);
  assign last_c  = (sum_q[ADDR_W:OFF_W] > (HI_W + 1)'(NUM_PAGES)) ? PAGE_W'(NUM_PAGES)
                                                                  : PAGE_W'(sum_q[ADDR_W:OFF_W]);

  assign fr_diff  = cmd_q.free_address - virt_offset;
  assign free_hit = fr_ok && rdata[fbit];
  assign alloc_ok = (cmd.page_count != '0) && (int'(cmd.page_count) <= NUM_PAGES);

  assign usable_sum = {1'b0, usable_pages} + (FREE_W + 1)'(lc - fc);
  assign used_sum   = UADD_W'(pages_held) + UADD_W'(cnt);
  assign free_cnt   = (usable_pages > FREE_W'(pages_held)) ? usable_pages - FREE_W'(pages_held)
                                                           : '0;

  bpa_bitmap_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (widx),
    .wdata (mem_wdata),
    .raddr (widx_next),
    .rdata (rdata)
  );

  bpa_run_step u_step (
    .seg     (seg),
    .run_in  (run),
    .cnt     (cnt),
    .run_out (st_run),
    .hit     (st_hit),
    .pos     (st_pos)
  );

  bpa_mask_gen u_mask (
    .widx (widx),
    .lo   (lo),
    .hi   (hi),
    .mask (mask)
  );

  always_comb begin
    state_next = state;
    widx_next  = widx;
    bidx_next  = bidx;
    run_next   = run;
    mem_we     = 1'b0;
    mem_wdata  = rdata;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
        if (scan_last) begin
          state_next = S_IDLE;
        end else begin
          widx_next = widx + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_REGION: begin
              state_next = cmd.region_usable ? S_RG_SUM : S_REPORT;
            end
            ACT_ALLOC: begin
              if (alloc_ok) begin
                widx_next  = '0;
                run_next   = '0;
                state_next = S_SCAN;
              end else begin
                state_next = S_REPORT;
              end
            end
            ACT_FREE: begin
              state_next = S_FR_SUB;
            end
            default: begin
              state_next = S_REPORT;
            end
          endcase
        end
      end
      S_RG_SUM: begin
        state_next = S_RG_CLAMP;
      end
      S_RG_CLAMP: begin
        state_next = S_RG_CNT;
      end
      S_RG_CNT: begin
        if (fc >= lc) begin
          state_next = S_REPORT;
        end else begin
          widx_next  = WIDX_W'(fc >> BIT_W);
          state_next = S_RMW;
        end
      end
      S_SCAN: begin
        if (word_all_free && zw_hit) begin
          state_next = S_AL_MARK;
        end else if (!word_all_used && !word_all_free) begin
          bidx_next  = '0;
          state_next = S_BYTE;
        end else begin
          run_next = word_all_used ? '0 : PAGE_W'(run_wide);
          if (scan_last) begin
            state_next = S_REPORT;
          end else begin
            widx_next = widx + 1'b1;
          end
        end
      end
      S_BYTE: begin
        if (st_hit) begin
          state_next = S_AL_MARK;
        end else begin
          run_next = st_run;
          if (byte_last) begin
            if (scan_last) begin
              state_next = S_REPORT;
            end else begin
              widx_next  = widx + 1'b1;
              state_next = S_SCAN;
            end
          end else begin
            bidx_next = bidx + 1'b1;
          end
        end
      end
      S_AL_MARK: begin
        widx_next  = WIDX_W'(start_q >> BIT_W);
        state_next = S_RMW;
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_wdata = op_set ? (rdata | mask) : (rdata & ~mask);
        if (rmw_last) begin
          state_next = op_set ? S_AL_ADDR : S_REPORT;
        end else begin
          widx_next = widx + 1'b1;
        end
      end
      S_AL_ADDR: begin
        state_next = S_REPORT;
      end
      S_FR_SUB: begin
        widx_next  = WIDX_W'(fr_diff >> (OFF_W + BIT_W));
        state_next = S_FR_CHK;
      end
      S_FR_CHK: begin
        if (free_hit) begin
          mem_we    = 1'b1;
          mem_wdata = rdata & ~(word_t'(1) << fbit);
        end
        state_next = S_REPORT;
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      widx         <= '0;
      bidx         <= '0;
      run          <= '0;
      done         <= 1'b0;
      virt_offset  <= '0;
      pages_held   <= '0;
      usable_pages <= '0;
      memory_bytes <= '0;
    end else begin
      state <= state_next;
      widx  <= widx_next;
      bidx  <= bidx_next;
      run   <= run_next;
      done  <= (state == S_REPORT);
      if (cfg_we) begin
        virt_offset <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (accept && cmd.action == ACT_REGION) begin
            memory_bytes <= memory_bytes + cmd.region_length;
          end
        end
        S_RG_CNT: begin
          if (fc < lc) begin
            usable_pages <= usable_sum[FREE_W] ? '1 : usable_sum[FREE_W-1:0];
          end
        end
        S_AL_MARK: begin
          pages_held <= (used_sum > UADD_W'(USED_MAX)) ? USED_MAX : CNT_W'(used_sum);
        end
        S_FR_CHK: begin
          if (free_hit && pages_held != '0) begin
            pages_held <= pages_held - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q   <= cmd;
          addr_q  <= '0;
          found_q <= 1'b0;
          if (cmd.action == ACT_ALLOC && cmd.page_count == '0) begin
            addr_q  <= virt_offset;
            found_q <= 1'b1;
          end
        end
      end
      S_RG_SUM: begin
        sum_q   <= {1'b0, cmd_q.region_base} + {1'b0, cmd_q.region_length};
        first_q <= (HI_W + 1)'(cmd_q.region_base[ADDR_W-1:OFF_W])
                   + (HI_W + 1)'(|cmd_q.region_base[OFF_W-1:0]);
      end
      S_RG_CLAMP: begin
        fc <= first_c;
        lc <= last_c;
      end
      S_RG_CNT: begin
        lo     <= PIDX_W'(fc);
        hi     <= PIDX_W'(lc - 1'b1);
        op_set <= 1'b0;
      end
      S_SCAN: begin
        word_q <= rdata;
        if (word_all_free && zw_hit) begin
          start_q <= zw_start;
        end
      end
      S_BYTE: begin
        if (st_hit) begin
          start_q <= by_start_w[PIDX_W-1:0];
        end
      end
      S_AL_MARK: begin
        lo     <= start_q;
        hi     <= PIDX_W'(PAGE_W'(start_q) + cnt - 1'b1);
        op_set <= 1'b1;
      end
      S_AL_ADDR: begin
        addr_q  <= (ADDR_W'(start_q) << OFF_W) + virt_offset;
        found_q <= 1'b1;
      end
      S_FR_SUB: begin
        fr_ok <= ((fr_diff >> (OFF_W + PIDX_W)) == '0);
        fbit  <= fr_diff[OFF_W+BIT_W-1:OFF_W];
      end
      S_REPORT: begin
        result.address     <= addr_q;
        result.found       <= found_q;
        result.used_count  <= pages_held;
        result.free_count  <= free_cnt;
        result.total_bytes <= memory_bytes;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/bpa_checker.sv
`include "bitmap_page_allocator_assert.svh"

module bpa_checker import bpa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input out_item_t result
);

  `BPA_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `BPA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `BPA_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `BPA_ASSERT_IMP(a_miss_zero, clk, rst, done && !result.found, result.address == '0)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
